### rtl/core/utf8_to_ucs2_decoder_assert.svh
// Assertion macros for the decoder RTL.
`ifndef UTF8_TO_UCS2_DECODER_ASSERT_SVH
`define UTF8_TO_UCS2_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define UTF8DEC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define UTF8DEC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/utf8dec_pkg.sv
package utf8dec_pkg;

   typedef enum logic [3:0] {
      PH_LEAD       = 4'b0001,
      PH_TWO_LAST   = 4'b0010,
      PH_THREE_MID  = 4'b0100,
      PH_THREE_LAST = 4'b1000
   } phase_type;

   localparam logic [7:0] ASCII_LIMIT = 8'h80;
   localparam logic [7:0] LEAD4_MIN   = 8'hF0;
   localparam logic [7:0] LEAD2_MASK  = 8'hE0;
   localparam logic [7:0] LEAD2_CODE  = 8'hC0;
   localparam logic [7:0] CONT_MASK   = 8'hC0;
   localparam logic [7:0] CONT_CODE   = 8'h80;
   localparam logic [7:0] TERMINATOR  = 8'h00;

   typedef struct packed {
      logic        emit;
      logic [15:0] code_unit;
      logic        end_of_string;
      logic        bad_sequence;
   } result_type;

endpackage

### rtl/core/utf8dec_fsm.sv
module utf8dec_fsm (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic [7:0]              in_byte,
   output utf8dec_pkg::result_type result
);

   utf8dec_pkg::phase_type phase_ff, phase_in;
   logic [9:0]             partial_ff, partial_in;
   logic                   skipping_ff, skipping_in;
   logic                   cont_ok;
   logic                   term_seen;
   logic                   state_idle;
   logic                   reset_state;
   logic                   flagged;
   logic                   flag_ok;
   logic                   error_seen;

   assign cont_ok = (in_byte & utf8dec_pkg::CONT_MASK) == utf8dec_pkg::CONT_CODE;

   always_comb begin
      result      = '0;
      phase_in    = phase_ff;
      partial_in  = partial_ff;
      skipping_in = skipping_ff;
      if (in_byte == utf8dec_pkg::TERMINATOR) begin
         result.emit          = 1'b1;
         result.end_of_string = 1'b1;
         result.bad_sequence  = !skipping_ff && (phase_ff != utf8dec_pkg::PH_LEAD);
         phase_in             = utf8dec_pkg::PH_LEAD;
         partial_in           = '0;
         skipping_in          = 1'b0;
      end else if (!skipping_ff) begin
         unique case (phase_ff) inside
            utf8dec_pkg::PH_LEAD: begin
               if (in_byte < utf8dec_pkg::ASCII_LIMIT) begin
                  result.emit      = 1'b1;
                  result.code_unit = {8'h00, in_byte};
               end else if (in_byte >= utf8dec_pkg::LEAD4_MIN) begin
                  result.emit         = 1'b1;
                  result.bad_sequence = 1'b1;
                  skipping_in         = 1'b1;
                  partial_in          = '0;
               end else if ((in_byte & utf8dec_pkg::LEAD2_MASK) == utf8dec_pkg::LEAD2_CODE) begin
                  partial_in = {5'b00000, in_byte[4:0]};
                  phase_in   = utf8dec_pkg::PH_TWO_LAST;
               end else begin
                  partial_in = {6'b000000, in_byte[3:0]};
                  phase_in   = utf8dec_pkg::PH_THREE_MID;
               end
            end
            utf8dec_pkg::PH_TWO_LAST, utf8dec_pkg::PH_THREE_MID,
            utf8dec_pkg::PH_THREE_LAST: begin
               if (!cont_ok) begin
                  result.emit         = 1'b1;
                  result.bad_sequence = 1'b1;
                  skipping_in         = 1'b1;
                  phase_in            = utf8dec_pkg::PH_LEAD;
                  partial_in          = '0;
               end else if (phase_ff == utf8dec_pkg::PH_THREE_MID) begin
                  partial_in = {partial_ff[3:0], in_byte[5:0]};
                  phase_in   = utf8dec_pkg::PH_THREE_LAST;
               end else begin
                  result.emit      = 1'b1;
                  result.code_unit = {partial_ff, in_byte[5:0]};
                  phase_in         = utf8dec_pkg::PH_LEAD;
                  partial_in       = '0;
               end
            end
            default: begin
               phase_in   = utf8dec_pkg::PH_LEAD;
               partial_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= utf8dec_pkg::PH_LEAD;
         partial_ff  <= '0;
         skipping_ff <= 1'b0;
      end else if (advance) begin
         phase_ff    <= phase_in;
         partial_ff  <= partial_in;
         skipping_ff <= skipping_in;
      end
   end

   assign term_seen   = advance && (in_byte == utf8dec_pkg::TERMINATOR);
   assign state_idle  = (phase_ff == utf8dec_pkg::PH_LEAD) && (partial_ff == '0);
   assign reset_state = state_idle && !skipping_ff;
   assign flagged     = result.end_of_string || result.bad_sequence;
   assign flag_ok     = result.emit && (result.code_unit == 16'h0000);
   assign error_seen  = advance && result.bad_sequence && !result.end_of_string;

`include "utf8_to_ucs2_decoder_assert.svh"

   `UTF8DEC_ASSERT_NEXT(a_term_clears, clock, reset, term_seen, reset_state, "no clear at end")
   `UTF8DEC_ASSERT_NOW(a_skip_in_lead, clock, reset, skipping_ff, state_idle, "skip not in lead")
   `UTF8DEC_ASSERT_NOW(a_flag_unit_zero, clock, reset, flagged, flag_ok, "flag with unit")
   `UTF8DEC_ASSERT_NEXT(a_error_skips, clock, reset, error_seen, skipping_ff, "skip not set")

endmodule

### rtl/core/utf8_to_ucs2_decoder.sv
// UTF-8 to UCS-2 decoder.
// Input channel: req_valid / req_stall carry one byte of a zero-terminated
// UTF-8 string in req_in_byte. Output channel: rsp_valid / rsp_stall carry
// one 16-bit code unit with rsp_end_of_string and rsp_bad_sequence flags.
// A word moves at a rising edge with valid high and stall low.
// Each byte passes an input register, then the decode step, then the result
// register: a result word is held in the result register once its byte has
// been decoded, and leaves when rsp_stall is low. Lead bytes of two- and three-
// byte sequences and middle bytes of a sequence give no result word.
// Throughput is one byte per cycle while the receiver does not stall, set by
// the combinational decode step and its state registers; a byte is taken
// while the result register holds an earlier word leaving in the same cycle.
// A lead of 0xF0 or above, or a bad continuation byte, gives one word with
// rsp_bad_sequence set; later bytes are dropped until the zero byte, which
// gives the end word and returns the decoder to its reset state.
// When the receiver stalls, the result word holds and req_stall rises once
// the input register is full. Synchronous reset empties both registers and
// puts the decoder in the lead-byte phase.
module utf8_to_ucs2_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_code_unit,
   output logic        rsp_end_of_string,
   output logic        rsp_bad_sequence
);

   logic                    in_valid_ff;
   logic [7:0]              in_byte_ff;
   logic                    out_valid_ff, out_valid_in;
   logic [15:0]             out_code_unit_ff;
   logic                    out_end_ff;
   logic                    out_bad_ff;
   logic                    out_free;
   logic                    advance;
   utf8dec_pkg::result_type result;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   utf8dec_fsm u_fsm (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_byte (in_byte_ff),
      .result  (result)
   );

   assign out_valid_in = advance && result.emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_byte_ff <= req_in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && out_valid_in) begin
         out_code_unit_ff <= result.code_unit;
         out_end_ff       <= result.end_of_string;
         out_bad_ff       <= result.bad_sequence;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_code_unit     = out_code_unit_ff;
   assign rsp_end_of_string = out_end_ff;
   assign rsp_bad_sequence  = out_bad_ff;

endmodule
